// File: rtl/core/ftla_pkg.sv
`default_nettype none
package ftla_pkg;

    localparam int FRAME_COUNT_DEF = 256;
    localparam logic [61:0] NS_PER_SEC = 62'd1000000000;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [2:0] STS_FREE     = 3'd0;
    localparam logic [2:0] STS_EVICT    = 3'd1;
    localparam logic [2:0] STS_RANGE    = 3'd2;
    localparam logic [2:0] STS_RELEASED = 3'd3;
    localparam logic [2:0] STS_READ     = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [14:0] owner;
        logic [7:0]  page;
        logic        dirty;
        logic [62:0] stamp;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_ADD,
        ST_SCAN,
        ST_COMMIT,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mul;
        logic add;
        logic scan_step;
        logic commit;
        logic rd_issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic page_ok;
        logic clr_done;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/ftla_ram.sv
`default_nettype none
module ftla_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: rtl/core/ftla_ctrl.sv
`default_nettype none
module ftla_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ftla_pkg::sts_t sts,
    output ftla_pkg::cmd_t     cmd
);
    import ftla_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (sts.op)
                    OP_REQUEST: state_next = sts.page_ok ? ST_MUL : ST_FINISH;
                    OP_RELEASE: state_next = ST_SCAN;
                    OP_READ:    state_next = ST_RD_ISSUE;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_MUL:      state_next = ST_ADD;
            ST_ADD:      state_next = ST_SCAN;
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = (sts.op == OP_REQUEST) ? ST_COMMIT : ST_FINISH;
                end
            end
            ST_COMMIT:   state_next = ST_FINISH;
            ST_RD_ISSUE: state_next = ST_RD_WAIT;
            ST_RD_WAIT:  state_next = ST_FINISH;
            ST_FINISH:   if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.clr_step  = (state_reg == ST_CLEAR);
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.mul       = (state_reg == ST_MUL);
        cmd.add       = (state_reg == ST_ADD);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.commit    = (state_reg == ST_COMMIT);
        cmd.rd_issue  = (state_reg == ST_RD_ISSUE);
        cmd.out_load  = (state_reg == ST_FINISH) && sts.out_free;
    end
endmodule
`default_nettype wire

// File: rtl/core/ftla_datapath.sv
`default_nettype none
module ftla_datapath #(
    parameter int FRAME_COUNT = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ftla_pkg::cmd_t cmd,
    output ftla_pkg::sts_t     sts,
    input  wire logic [1:0]    s_operation,
    input  wire logic [14:0]   s_process_id,
    input  wire logic [8:0]    s_page,
    input  wire logic          s_write_access,
    input  wire logic [31:0]   s_time_seconds,
    input  wire logic [29:0]   s_time_nanoseconds,
    input  wire logic [7:0]    s_frame_select,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_slot_index,
    output logic [14:0]        m_evicted_process,
    output logic [7:0]         m_evicted_page,
    output logic               m_entry_valid,
    output logic [14:0]        m_entry_process,
    output logic [7:0]         m_entry_page,
    output logic               m_entry_dirty,
    output logic [61:0]        m_entry_stamp
);
    import ftla_pkg::*;

    localparam int AW = $clog2(FRAME_COUNT);
    localparam int CW = AW + 1;
    localparam int EW = $bits(entry_t);

    // captured item
    op_t         op_reg;
    logic [14:0] pid_reg;
    logic [8:0]  page_reg;
    logic        wr_reg;
    logic [31:0] secs_reg;
    logic [29:0] nsec_reg;
    logic [7:0]  sel_reg;
    logic [61:0] prod_reg;
    logic [62:0] stamp_reg;

    // scan state
    logic [CW-1:0] cnt_reg;
    logic          rvld_reg;
    logic [AW-1:0] addr_d_reg;
    logic          found_reg;
    logic [AW-1:0] free_idx_reg;
    logic [AW-1:0] vic_idx_reg;
    logic [62:0]   min_stamp_reg;
    logic [14:0]   vic_owner_reg;
    logic [7:0]    vic_page_reg;

    logic          m_valid_reg;
    logic [2:0]    status_reg;
    logic [7:0]    slot_index_reg;
    logic [14:0]   ev_proc_reg;
    logic [7:0]    ev_page_reg;
    entry_t        entry_reg;

    logic [2:0]    status_next;
    logic [7:0]    slot_index_next;
    logic [14:0]   ev_proc_next;
    logic [7:0]    ev_page_next;
    entry_t        entry_next;

    logic          ram_we, ram_re, rel_hit, issue, sel_ok;
    logic [AW-1:0] ram_waddr, ram_raddr, target;
    entry_t        ram_wdata, ram_q, new_entry;
    logic [EW-1:0] ram_q_bits;

    assign ram_q  = entry_t'(ram_q_bits);
    assign issue  = cmd.scan_step && (cnt_reg != CW'(FRAME_COUNT));
    assign sel_ok = (32'(sel_reg) < 32'(FRAME_COUNT));
    assign rel_hit = rvld_reg && (op_reg == OP_RELEASE) && ram_q.valid
                     && (ram_q.owner == pid_reg);
    assign target = found_reg ? free_idx_reg : vic_idx_reg;

    always_comb begin
        new_entry       = '0;
        new_entry.valid = 1'b1;
        new_entry.owner = pid_reg;
        new_entry.page  = page_reg[7:0];
        new_entry.dirty = wr_reg;
        new_entry.stamp = stamp_reg;
    end

    always_comb begin
        ram_we    = cmd.clr_step || rel_hit || cmd.commit;
        ram_wdata = cmd.commit ? new_entry : '0;
        if (cmd.clr_step) begin
            ram_waddr = cnt_reg[AW-1:0];
        end else if (rel_hit) begin
            ram_waddr = addr_d_reg;
        end else begin
            ram_waddr = target;
        end
        ram_re    = issue || cmd.rd_issue;
        ram_raddr = cmd.rd_issue ? AW'(sel_reg) : cnt_reg[AW-1:0];
    end

    ftla_ram #(
        .WIDTH (EW),
        .DEPTH (FRAME_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q_bits)
    );

    always_comb begin
        status_next     = STS_READ;
        slot_index_next = '0;
        ev_proc_next    = '0;
        ev_page_next    = '0;
        entry_next      = '0;
        unique case (op_reg)
            OP_REQUEST: begin
                if (!sts.page_ok) begin
                    status_next = STS_RANGE;
                end else if (found_reg) begin
                    status_next     = STS_FREE;
                    slot_index_next = 8'(free_idx_reg);
                end else begin
                    status_next     = STS_EVICT;
                    slot_index_next = 8'(vic_idx_reg);
                    ev_proc_next    = vic_owner_reg;
                    ev_page_next    = vic_page_reg;
                end
            end
            OP_RELEASE: status_next = STS_RELEASED;
            default: begin
                if (sel_ok) begin
                    entry_next = ram_q;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= op_t'(s_operation);
            pid_reg  <= s_process_id;
            page_reg <= s_page;
            wr_reg   <= s_write_access;
            secs_reg <= s_time_seconds;
            nsec_reg <= s_time_nanoseconds;
            sel_reg  <= s_frame_select;
        end
        if (cmd.mul) begin
            prod_reg <= 62'(secs_reg) * NS_PER_SEC;
        end
        if (cmd.add) begin
            stamp_reg <= 63'(prod_reg) + 63'(nsec_reg);
        end
        addr_d_reg <= ram_raddr;
        // track first free frame and oldest stamp in one pass
        if (rvld_reg && (op_reg == OP_REQUEST)) begin
            if (!ram_q.valid && !found_reg) begin
                free_idx_reg <= addr_d_reg;
            end
            if ((addr_d_reg == '0) || (ram_q.stamp < min_stamp_reg)) begin
                min_stamp_reg <= ram_q.stamp;
                vic_idx_reg   <= addr_d_reg;
                vic_owner_reg <= ram_q.owner;
                vic_page_reg  <= ram_q.page;
            end
        end
        if (cmd.out_load) begin
            status_reg     <= status_next;
            slot_index_reg <= slot_index_next;
            ev_proc_reg    <= ev_proc_next;
            ev_page_reg    <= ev_page_next;
            entry_reg      <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            rvld_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rvld_reg <= ram_re;
            if (cmd.load) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.clr_step || issue) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (rvld_reg && (op_reg == OP_REQUEST) && !ram_q.valid) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts           = '0;
        sts.op        = op_reg;
        sts.page_ok   = (32'(page_reg) < 32'(FRAME_COUNT));
        sts.clr_done  = (cnt_reg == CW'(FRAME_COUNT - 1));
        sts.scan_last = rvld_reg && (addr_d_reg == AW'(FRAME_COUNT - 1));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_slot_index      = slot_index_reg;
    assign m_evicted_process = ev_proc_reg;
    assign m_evicted_page    = ev_page_reg;
    assign m_entry_valid     = entry_reg.valid;
    assign m_entry_process   = entry_reg.owner;
    assign m_entry_page      = entry_reg.page;
    assign m_entry_dirty     = entry_reg.dirty;
    assign m_entry_stamp     = entry_reg.stamp[61:0];
endmodule
`default_nettype wire

// File: rtl/core/frame_table_lru_allocator_core.sv
`default_nettype none
// channel  | ports      | handshake       | payload
// input    | s_*        | s_valid/s_ready | operation, process_id, page, write_access,
//          |            |                 | time_seconds, time_nanoseconds, frame_select
// result   | m_*        | m_valid/m_ready | status, slot_index, evicted_*, entry_*
//
// Request and release scan the whole frame RAM through its single read port.
// From dispatch, a request passes multiply, add, scan and commit; a release the scan;
// a read the RAM read issue and wait; an out-of-range request none. Each then loads
// its result into the output register. The unused operation gives no result and
// goes back to idle. The block returns to idle before the next item is taken.
// After reset the RAM is cleared one frame a cycle; s_ready stays low until then.
// One item is in work at a time; a new item is taken while a result waits in
// the output register, and the block stalls at the end only if it is still held.
module frame_table_lru_allocator_core #(
    parameter int FRAME_COUNT = ftla_pkg::FRAME_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [14:0] s_process_id,
    input  wire logic [8:0]  s_page,
    input  wire logic        s_write_access,
    input  wire logic [31:0] s_time_seconds,
    input  wire logic [29:0] s_time_nanoseconds,
    input  wire logic [7:0]  s_frame_select,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_slot_index,
    output logic [14:0]      m_evicted_process,
    output logic [7:0]       m_evicted_page,
    output logic             m_entry_valid,
    output logic [14:0]      m_entry_process,
    output logic [7:0]       m_entry_page,
    output logic             m_entry_dirty,
    output logic [61:0]      m_entry_stamp
);
    import ftla_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ftla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ftla_datapath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_operation        (s_operation),
        .s_process_id       (s_process_id),
        .s_page             (s_page),
        .s_write_access     (s_write_access),
        .s_time_seconds     (s_time_seconds),
        .s_time_nanoseconds (s_time_nanoseconds),
        .s_frame_select     (s_frame_select),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_slot_index       (m_slot_index),
        .m_evicted_process  (m_evicted_process),
        .m_evicted_page     (m_evicted_page),
        .m_entry_valid      (m_entry_valid),
        .m_entry_process    (m_entry_process),
        .m_entry_page       (m_entry_page),
        .m_entry_dirty      (m_entry_dirty),
        .m_entry_stamp      (m_entry_stamp)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.clr_step || cmd.commit || cmd.out_load))
        else $error("table or result written while idle");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result shown without a load");
endmodule
`default_nettype wire

// File: tb/frame_table_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module frame_table_checker
    import ftla_pkg::*;
#(
    parameter int FRAMES = ftla_pkg::FRAME_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [14:0] s_process_id,
    input  wire logic [8:0]  s_page,
    input  wire logic        s_write_access,
    input  wire logic [31:0] s_time_seconds,
    input  wire logic [29:0] s_time_nanoseconds,
    input  wire logic [7:0]  s_frame_select,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_status,
    input  wire logic [7:0]  m_slot_index,
    input  wire logic [14:0] m_evicted_process,
    input  wire logic [7:0]  m_evicted_page,
    input  wire logic        m_entry_valid,
    input  wire logic [14:0] m_entry_process,
    input  wire logic [7:0]  m_entry_page,
    input  wire logic        m_entry_dirty,
    input  wire logic [61:0] m_entry_stamp,
    output int               mismatch_count,
    output int               pending_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_index;
        logic [14:0] evicted_process;
        logic [7:0]  evicted_page;
        logic        entry_valid;
        logic [14:0] entry_process;
        logic [7:0]  entry_page;
        logic        entry_dirty;
        logic [61:0] entry_stamp;
    } outcome_t;

    entry_t   frames [FRAMES];
    outcome_t expected_outcomes [$];

    assign pending_count = expected_outcomes.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic outcome_t allocate_frame(input logic [1:0] op, input logic [14:0] pid,
                                                input logic [8:0] pg, input logic wr,
                                                input logic [31:0] secs,
                                                input logic [29:0] nsec,
                                                input logic [7:0] sel);
        outcome_t res;
        logic [63:0] stamp;
        int victim;
        bit placed;
        res = '0;
        placed = 0;
        case (op)
            OP_REQUEST: begin
                stamp = 64'(secs) * 64'd1000000000 + 64'(nsec);
                if (pg >= FRAMES) begin
                    res.status = STS_RANGE;
                end else begin
                    for (int i = 0; i < FRAMES && !placed; i++) begin
                        if (!frames[i].valid) begin
                            victim = i;
                            placed = 1;
                        end
                    end
                    if (placed) begin
                        res.status = STS_FREE;
                    end else begin
                        victim = 0;
                        for (int i = 1; i < FRAMES; i++) begin
                            if (frames[i].stamp < frames[victim].stamp) victim = i;
                        end
                        res.status = STS_EVICT;
                        res.evicted_process = frames[victim].owner;
                        res.evicted_page = frames[victim].page;
                    end
                    res.slot_index = victim[7:0];
                    frames[victim] = '{1'b1, pid, pg[7:0], wr, stamp[62:0]};
                end
            end
            OP_RELEASE: begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (frames[i].valid && frames[i].owner == pid) frames[i] = '0;
                end
                res.status = STS_RELEASED;
            end
            default: begin
                res.status = STS_READ;
                if (sel < FRAMES) begin
                    res.entry_valid = frames[sel].valid;
                    res.entry_process = frames[sel].owner;
                    res.entry_page = frames[sel].page;
                    res.entry_dirty = frames[sel].dirty;
                    res.entry_stamp = frames[sel].stamp[61:0];
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            foreach (frames[i]) frames[i] = '0;
            expected_outcomes.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected item, status", m_status, 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_status != want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_slot_index != want.slot_index)
                        report_mismatch("slot_index", m_slot_index, want.slot_index);
                    if (m_evicted_process != want.evicted_process)
                        report_mismatch("evicted_process", m_evicted_process,
                                        want.evicted_process);
                    if (m_evicted_page != want.evicted_page)
                        report_mismatch("evicted_page", m_evicted_page, want.evicted_page);
                    if (m_entry_valid != want.entry_valid)
                        report_mismatch("entry_valid", m_entry_valid, want.entry_valid);
                    if (m_entry_process != want.entry_process)
                        report_mismatch("entry_process", m_entry_process, want.entry_process);
                    if (m_entry_page != want.entry_page)
                        report_mismatch("entry_page", m_entry_page, want.entry_page);
                    if (m_entry_dirty != want.entry_dirty)
                        report_mismatch("entry_dirty", m_entry_dirty, want.entry_dirty);
                    if (m_entry_stamp != want.entry_stamp)
                        report_mismatch("entry_stamp", m_entry_stamp, want.entry_stamp);
                end
            end
            if (s_valid && s_ready && s_operation != OP_NONE)
                expected_outcomes.push_back(allocate_frame(s_operation, s_process_id, s_page,
                                                           s_write_access, s_time_seconds,
                                                           s_time_nanoseconds,
                                                           s_frame_select));
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_frame_table_lru_allocator_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_frame_table_lru_allocator_core;
    import ftla_pkg::*;

    localparam int RANDOM_ITEMS = 1230;
    localparam longint CYCLE_LIMIT = 4000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [14:0] s_process_id;
    logic [8:0]  s_page;
    logic        s_write_access;
    logic [31:0] s_time_seconds;
    logic [29:0] s_time_nanoseconds;
    logic [7:0]  s_frame_select;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [7:0]  m_slot_index;
    logic [14:0] m_evicted_process;
    logic [7:0]  m_evicted_page;
    logic        m_entry_valid;
    logic [14:0] m_entry_process;
    logic [7:0]  m_entry_page;
    logic        m_entry_dirty;
    logic [61:0] m_entry_stamp;
    int          mismatch_count;
    int          pending_count;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          hold_off_sink;
    longint      cycle_count;
    logic [31:0] clock_seconds;

    frame_table_lru_allocator_core dut (.*);

    frame_table_checker checker_inst (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        bit hold_done;
        m_ready = 0;
        stall_left = 0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_sink && !hold_done) begin
                stall_left = 3000;
                hold_done = 1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [14:0] pid,
                             input logic [8:0] pg, input logic wr,
                             input logic [31:0] secs, input logic [29:0] nsec,
                             input logic [7:0] sel);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_process_id <= pid;
        s_page <= pg;
        s_write_access <= wr;
        s_time_seconds <= secs;
        s_time_nanoseconds <= nsec;
        s_frame_select <= sel;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // advancing time keeps stamps distinct most of the time; some repeat for ties
    task automatic send_request(input logic [14:0] pid, input logic [8:0] pg);
        logic [29:0] nsec;
        if ($urandom_range(9) != 0) clock_seconds = clock_seconds + $urandom_range(3);
        nsec = ($urandom_range(19) == 0) ? 30'h3FFFFFFF : 30'($urandom_range(999999999));
        send_item(OP_REQUEST, pid, pg, 1'($urandom), clock_seconds, nsec, 8'($urandom));
    endtask

    task automatic random_phase(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_request(15'($urandom_range(7)) | ($urandom_range(3) == 0 ?
                             15'($urandom) : 15'd0),
                             ($urandom_range(15) == 0) ? 9'($urandom) : 9'($urandom_range(255)));
            else if (pick < 65)
                send_item(OP_RELEASE, 15'($urandom_range(7)), 9'($urandom), 1'($urandom),
                          $urandom, 30'($urandom), 8'($urandom));
            else if (pick < 97)
                send_item(OP_READ, 15'($urandom), 9'($urandom), 1'($urandom), $urandom,
                          30'($urandom), 8'($urandom));
            else
                send_item(OP_NONE, 15'($urandom), 9'($urandom), 1'($urandom), $urandom,
                          30'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        s_valid = 0;
        s_operation = OP_NONE;
        s_process_id = 0;
        s_page = 0;
        s_write_access = 0;
        s_time_seconds = 0;
        s_time_nanoseconds = 0;
        s_frame_select = 0;
        aresetn = 0;
        hold_off_sink = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        clock_seconds = 5;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, out-of-range page, empty release, unused op
        send_item(OP_READ, 0, 0, 0, 0, 0, 8'd0);
        send_item(OP_REQUEST, 15'h7FFF, 9'd255, 1, 32'hFFFFFFFF, 30'h3FFFFFFF, 8'hFF);
        send_item(OP_REQUEST, 15'd0, 9'd0, 0, 32'd0, 30'd0, 8'd0);
        send_item(OP_REQUEST, 15'd3, 9'd256, 1, 32'd7, 30'd9, 8'd0);
        send_item(OP_REQUEST, 15'd3, 9'h1FF, 1, 32'd7, 30'd9, 8'd0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 8'd0);
        send_item(OP_READ, 15'h7FFF, 9'h1FF, 1, 32'hFFFFFFFF, 30'h3FFFFFFF, 8'd1);
        send_item(OP_READ, 0, 0, 0, 0, 0, 8'hFF);
        send_item(OP_NONE, 15'h7FFF, 9'h1FF, 1, 32'hFFFFFFFF, 30'h3FFFFFFF, 8'hFF);
        send_item(OP_RELEASE, 15'd1234, 0, 0, 0, 0, 0);
        send_item(OP_RELEASE, 15'h7FFF, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 8'd0);
        // fill the table so later requests evict
        for (int i = 0; i < 258; i++) send_request(15'($urandom_range(7)), 9'(i % 256));
        send_item(OP_READ, 0, 0, 0, 0, 0, 8'd2);

        // long receiver hold-off while items keep coming
        hold_off_sink = 1;
        for (int i = 0; i < 6; i++)
            send_item(OP_READ, 0, 0, 0, 0, 0, 8'($urandom));

        sender_idle_pct = 8;
        receiver_idle_pct = 63;
        random_phase(RANDOM_ITEMS / 3);
        sender_idle_pct = 63;
        receiver_idle_pct = 8;
        random_phase(RANDOM_ITEMS / 3);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(RANDOM_ITEMS / 3);
        s_valid <= 0;

        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

// File: frame_table_lru_allocator_core.f
rtl/core/ftla_pkg.sv
rtl/core/ftla_ram.sv
rtl/core/ftla_ctrl.sv
rtl/core/ftla_datapath.sv
rtl/core/frame_table_lru_allocator_core.sv
tb/frame_table_checker.sv
tb/tb_frame_table_lru_allocator_core.sv
